[hw/rtl/radial_gradient_dither_shader_core_macros.svh]
// assertion macros for the radial gradient dither shader core
// expects clk and arst_n in the scope of every use
`ifndef RADIAL_GRADIENT_DITHER_SHADER_CORE_MACROS_SVH
`define RADIAL_GRADIENT_DITHER_SHADER_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define RGDS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define RGDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/rgds_pkg.sv]
// shared types and constants of the radial gradient dither shader
// no dependencies
`timescale 1ns / 1ps

package rgds_pkg;

	localparam int TABLE_INDEX_BITS_DEF = 8;
	localparam int SCREEN_WIDTH_DEF     = 1024;
	localparam int SCREEN_HEIGHT_DEF    = 1024;

	localparam int COORD_W    = 10;
	localparam int TIDX_W     = 8;
	localparam int TVAL_W     = 16;
	localparam int CTR_W      = 16;
	localparam int IRS_W      = 32;
	localparam int SHADE_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 32;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_RADIUS2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SHIFT = 3'd4;

	localparam logic [3:0] INDEX_BITS_RST   = 4'd8;
	localparam logic [3:0] OUTPUT_SHIFT_RST = 4'd8;

	// operation codes carried in tuser
	localparam logic OP_TABLE_WRITE = 1'b0;
	localparam logic OP_SHADE       = 1'b1;

	typedef struct packed {
		logic              vld;
		logic              op;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [TIDX_W-1:0]  tidx;
		logic [TVAL_W-1:0]  tval;
	} rgds_item_t;

	typedef struct packed {
		logic               vld;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
	} rgds_pix_t;

endpackage

[hw/rtl/rgds_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module rgds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/rgds_dist.sv]
// distance pipeline: |dx|,|dy|, squares, sum, product with inverse radius squared
// depends on rgds_pkg
`timescale 1ns / 1ps

module rgds_dist #(
	parameter int SCREEN_WIDTH  = rgds_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = rgds_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  rgds_pkg::rgds_item_t           item_in,
	input  logic [rgds_pkg::CTR_W-1:0]     center_x,
	input  logic [rgds_pkg::CTR_W-1:0]     center_y,
	input  logic [rgds_pkg::IRS_W-1:0]     inv_radius2,
	output rgds_pkg::rgds_item_t           item_s4,
	output logic [31:0]                    prod_s4
);

	rgds_pkg::rgds_item_t item_s1, item_s2, item_s3;
	rgds_pkg::rgds_item_t item_kept;
	logic        on_screen;
	logic [16:0] dx, dy, ndx, ndy;
	logic [15:0] adx, ady;
	logic [15:0] adx_s1, ady_s1;
	logic [31:0] sq_x_s2, sq_y_s2;
	logic [31:0] dist2_s3;

	assign on_screen = (32'(item_in.px) < 32'(SCREEN_WIDTH))
		&& (32'(item_in.py) < 32'(SCREEN_HEIGHT));

	// clipped pixels leave the pipeline here
	always_comb begin
		item_kept     = item_in;
		item_kept.vld = item_in.vld
			&& (item_in.op == rgds_pkg::OP_TABLE_WRITE || on_screen);
	end

	// centre minus pixel, 17-bit two's complement; magnitude fits 16 bits
	assign dx  = {center_x[15], center_x} - {7'd0, item_in.px};
	assign dy  = {center_y[15], center_y} - {7'd0, item_in.py};
	assign ndx = 17'd0 - dx;
	assign ndy = 17'd0 - dy;
	assign adx = dx[16] ? ndx[15:0] : dx[15:0];
	assign ady = dy[16] ? ndy[15:0] : dy[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
			item_s2 <= '0;
			item_s3 <= '0;
			item_s4 <= '0;
		end else if (en) begin
			item_s1 <= item_kept;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
			item_s4 <= item_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1   <= adx;
			ady_s1   <= ady;
			sq_x_s2  <= 32'(adx_s1) * 32'(adx_s1);
			sq_y_s2  <= 32'(ady_s1) * 32'(ady_s1);
			// sum of two squares stays below 2^32
			dist2_s3 <= sq_x_s2 + sq_y_s2;
			// low 32 bits only, wraps as intended
			prod_s4  <= dist2_s3 * inv_radius2;
		end
	end

endmodule

[hw/rtl/rgds_shade.sv]
// dither, clamp, shift and saturate, then output register with skid stage
// depends on rgds_pkg
`timescale 1ns / 1ps

module rgds_shade (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rgds_pkg::rgds_pix_t               pix_s5,
	input  logic [rgds_pkg::TVAL_W-1:0]       entry,
	input  logic [3:0]                        output_shift,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [rgds_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                              skid_full
);

	localparam logic [4:0] BAYER4 [16] = '{
		5'd1,  5'd9,  5'd3,  5'd11,
		5'd13, 5'd5,  5'd15, 5'd7,
		5'd4,  5'd12, 5'd2,  5'd10,
		5'd16, 5'd8,  5'd14, 5'd6
	};

	logic [3:0]                     shift;
	logic [3:0]                     sh3;
	logic [4:0]                     t;
	logic signed [5:0]              tm8;
	logic signed [17:0]             off;
	logic signed [17:0]             sum;
	logic [16:0]                    pos;
	logic [16:0]                    lvl;
	logic [rgds_pkg::SHADE_W-1:0]   shade;
	logic [rgds_pkg::M_TDATA_W-1:0] word;
	logic                           out_vld_q, skid_vld_q;
	logic [rgds_pkg::M_TDATA_W-1:0] out_q, skid_q;

	always_comb begin
		if (output_shift < 4'd8) begin
			shift = 4'd8;
		end else if (output_shift > 4'd12) begin
			shift = 4'd12;
		end else begin
			shift = output_shift;
		end
	end

	assign sh3   = shift - 4'd3;
	assign t     = BAYER4[{pix_s5.py[1:0], pix_s5.px[1:0]}];
	assign tm8   = $signed({1'b0, t}) - 6'sd8;
	assign off   = 18'(tm8) <<< sh3;
	assign sum   = $signed({2'b00, entry}) + off;
	assign pos   = sum[17] ? 17'd0 : sum[16:0];
	assign lvl   = pos >> shift;
	assign shade = (lvl > 17'd255) ? 8'hFF : lvl[7:0];
	assign word  = {4'd0, shade, pix_s5.py, pix_s5.px};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_tready) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (!out_vld_q || m_tready) begin
			out_vld_q <= pix_s5.vld;
		end else if (pix_s5.vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (!out_vld_q || m_tready) begin
			out_q <= word;
		end else begin
			skid_q <= word;
		end
	end

	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_q;
	assign skid_full = skid_vld_q;

endmodule

[hw/rtl/radial_gradient_dither_shader_core.sv]
// radial gradient shader with 4x4 ordered dither, one word in and out per clock while the skid stage is empty
// path: stages one to four, stage five with the registered table read, then the output register on m_tdata
// throughput: one word per cycle while the skid stage is empty; stage four then issues one table write or read a cycle
// reset: pipeline and output flags cleared, registers to defaults, table undefined
// depends on rgds_pkg, rgds_ram, rgds_dist, rgds_shade and the macros header
`timescale 1ns / 1ps

`include "radial_gradient_dither_shader_core_macros.svh"

module radial_gradient_dither_shader_core #(
	parameter int TABLE_INDEX_BITS = rgds_pkg::TABLE_INDEX_BITS_DEF,
	parameter int SCREEN_WIDTH     = rgds_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT    = rgds_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_wr_en,
	input  logic [rgds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rgds_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// input words
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// pixel_x [9:0], pixel_y [19:10], table_index [27:20], table_value [43:28], zero pad
	input  logic [rgds_pkg::S_TDATA_W-1:0]     s_tdata,
	// operation: table write or shade
	input  logic                               s_tuser,
	// result words
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// result_x [9:0], result_y [19:10], shade [27:20], zero pad
	output logic [rgds_pkg::M_TDATA_W-1:0]     m_tdata
);

	localparam int         AW      = TABLE_INDEX_BITS;
	localparam int         DEPTH   = 1 << TABLE_INDEX_BITS;
	localparam logic [3:0] MAX_K   = 4'(TABLE_INDEX_BITS);

	// configuration registers
	logic [rgds_pkg::CTR_W-1:0] center_x_q, center_y_q;
	logic [rgds_pkg::IRS_W-1:0] inv_radius2_q;
	logic [3:0]                 index_bits_q, output_shift_q;

	// pipeline
	logic                       en;
	logic                       skid_full;
	rgds_pkg::rgds_item_t       item_in, item_s4;
	logic [31:0]                prod_s4;
	rgds_pkg::rgds_pix_t        pix_s5;

	// table access
	logic [3:0]                 k;
	logic [31:0]                prod_sh;
	logic [AW+rgds_pkg::TIDX_W-1:0] tidx_ext;
	logic [AW-1:0]              ram_waddr, ram_raddr;
	logic                       ram_we, ram_re;
	logic [rgds_pkg::TVAL_W-1:0] ram_rdata;

	// register writes; the user must make them only while the block is idle, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q     <= '0;
			center_y_q     <= '0;
			inv_radius2_q  <= '0;
			index_bits_q   <= rgds_pkg::INDEX_BITS_RST;
			output_shift_q <= rgds_pkg::OUTPUT_SHIFT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rgds_pkg::REG_CENTER_X: begin
					center_x_q <= cfg_wdata[rgds_pkg::CTR_W-1:0];
				end
				rgds_pkg::REG_CENTER_Y: begin
					center_y_q <= cfg_wdata[rgds_pkg::CTR_W-1:0];
				end
				rgds_pkg::REG_INV_RADIUS2: begin
					inv_radius2_q <= cfg_wdata[rgds_pkg::IRS_W-1:0];
				end
				rgds_pkg::REG_INDEX_BITS: begin
					index_bits_q <= cfg_wdata[3:0];
				end
				rgds_pkg::REG_OUTPUT_SHIFT: begin
					output_shift_q <= cfg_wdata[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	// whole pipeline moves together; it halts only once the skid stage holds a word,
	// so a word is still accepted while the output register waits
	assign en       = !skid_full;
	assign s_tready = en;

	assign item_in.vld  = s_tvalid && en;
	assign item_in.op   = s_tuser;
	assign item_in.px   = s_tdata[9:0];
	assign item_in.py   = s_tdata[19:10];
	assign item_in.tidx = s_tdata[27:20];
	assign item_in.tval = s_tdata[43:28];

	// stages one to four: distance squared times inverse radius squared
	rgds_dist #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.item_in     (item_in),
		.center_x    (center_x_q),
		.center_y    (center_y_q),
		.inv_radius2 (inv_radius2_q),
		.item_s4     (item_s4),
		.prod_s4     (prod_s4)
	);

	// index width saturated to the table depth; zero index bits gives entry zero
	assign k         = (index_bits_q > MAX_K) ? MAX_K : index_bits_q;
	assign prod_sh   = prod_s4 >> (6'd32 - {2'b00, k});
	assign ram_raddr = (k == 4'd0) ? '0 : prod_sh[AW-1:0];

	// write address is the table index masked to the depth
	assign tidx_ext  = {{AW{1'b0}}, item_s4.tidx};
	assign ram_waddr = tidx_ext[AW-1:0];

	// writes and reads are both issued from stage four in arrival order, one item a cycle
	// while the pipeline is enabled, so a read always sees every earlier write and the two never collide
	assign ram_we = en && item_s4.vld && (item_s4.op == rgds_pkg::OP_TABLE_WRITE);
	assign ram_re = en && item_s4.vld && (item_s4.op == rgds_pkg::OP_SHADE);

	rgds_ram #(
		.WIDTH (rgds_pkg::TVAL_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item_s4.tval),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// pixel coordinates travel alongside the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s5 <= '0;
		end else if (en) begin
			pix_s5.vld <= item_s4.vld && (item_s4.op == rgds_pkg::OP_SHADE);
			pix_s5.px  <= item_s4.px;
			pix_s5.py  <= item_s4.py;
		end
	end

	// stage five: dither and scale, then the output register and skid stage
	rgds_shade u_shade (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_s5       (pix_s5),
		.entry        (ram_rdata),
		.output_shift (output_shift_q),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.m_tdata      (m_tdata),
		.skid_full    (skid_full)
	);

	`RGDS_ASSERT_SAME(a_no_rw_clash, ram_we, !ram_re, "table write and read issued together")
	`RGDS_ASSERT_NEXT(a_read_tracked, ram_re, pix_s5.vld, "table read without pixel in stage five")
	`RGDS_ASSERT_SAME(a_skid_behind_out, skid_full, m_tvalid, "skid word held with empty output")

endmodule

[bench/radial_gradient_dither_shader_core_test.sv]
// self-checking bench for the radial gradient dither shader core
// streams table writes and pixels through the core and checks every shaded word
// depends on rgds_pkg and radial_gradient_dither_shader_core
`timescale 1ns / 1ps

module radial_gradient_dither_shader_core_test;

	import rgds_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 9;
	// five-stage pipeline plus a little margin before touching the registers
	localparam int DRAIN_CYCLES = 8;
	// cycles without any word moving on either side before the run is abandoned
	localparam int STALL_LIMIT  = 4000;
	localparam int PHASE_COUNT  = 9;
	localparam int PHASE_CHOICES = 200;
	localparam int SLOT_BITS    = TABLE_INDEX_BITS_DEF;
	localparam int SLOTS        = 1 << SLOT_BITS;

	// 4x4 ordered dither ranks, row-major by (y mod 4, x mod 4)
	localparam int DITHER_RANK [16] = '{1, 9, 3, 11, 13, 5, 15, 7, 4, 12, 2, 10, 16, 8, 14, 6};

	// one input word as the sender sees it
	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [TIDX_W-1:0]  tidx;
		logic [TVAL_W-1:0]  tval;
	} shader_word_t;

	// one shaded pixel as it should leave the core
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SHADE_W-1:0] level;
	} shaded_pixel_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_PERIODIC
	} ready_mode_e;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// pixel_x, pixel_y, table_index, table_value, zero pad (lowest bit first)
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	// operation
	logic                  s_tuser   = OP_TABLE_WRITE;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// result_x, result_y, shade, zero pad (lowest bit first)
	logic [M_TDATA_W-1:0]  m_tdata;

	// shadow copy of the register file and the gradient table
	logic signed [CTR_W-1:0] centre_x_q   = '0;
	logic signed [CTR_W-1:0] centre_y_q   = '0;
	logic [IRS_W-1:0]        inv_r2_q     = '0;
	logic [3:0]              index_bits_q = INDEX_BITS_RST;
	logic [3:0]              out_shift_q  = OUTPUT_SHIFT_RST;
	logic [TVAL_W-1:0]       gradient_mirror [SLOTS];

	// which entries the stimulus has already filled, so no pixel reads a blank entry
	bit slot_written [SLOTS];

	shader_word_t  queued_words [$];
	shaded_pixel_t pending_shades [$];
	int            failures = 0;

	always #HALF_PERIOD clk = ~clk;

	radial_gradient_dither_shader_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// table entry a pixel lands on under the current register settings
	function automatic int gradient_slot(input logic [COORD_W-1:0] px,
		input logic [COORD_W-1:0] py);
		int          dx;
		int          dy;
		int          k;
		logic [31:0] adx;
		logic [31:0] ady;
		logic [63:0] dist2;
		logic [63:0] wide;
		logic [31:0] prod;
		dx = int'(centre_x_q) - int'(px);
		dy = int'(centre_y_q) - int'(py);
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		dist2 = 64'(adx) * 64'(adx) + 64'(ady) * 64'(ady);
		// product wraps modulo 2^32
		wide = dist2 * 64'(inv_r2_q);
		prod = wide[31:0];
		// index width saturates at the table depth, zero means a single entry
		k = (index_bits_q > SLOT_BITS) ? SLOT_BITS : int'(index_bits_q);
		if (k == 0) begin
			return 0;
		end
		return int'((prod >> (32 - k)) & (SLOTS - 1));
	endfunction

	function automatic shaded_pixel_t shade_pixel(input shader_word_t w);
		int            s;
		int            rank;
		int            offset;
		int            sum;
		shaded_pixel_t r;
		// shift is held inside 8..12 whatever the register says
		if (out_shift_q < 8) begin
			s = 8;
		end else if (out_shift_q > 12) begin
			s = 12;
		end else begin
			s = int'(out_shift_q);
		end
		rank = DITHER_RANK[{w.py[1:0], w.px[1:0]}];
		offset = (rank - 8) * (1 << (s - 3));
		sum = int'(gradient_mirror[gradient_slot(w.px, w.py)]) + offset;
		if (sum < 0) begin
			sum = 0;
		end
		sum = sum >> s;
		r.x = w.px;
		r.y = w.py;
		r.level = (sum > 255) ? {SHADE_W{1'b1}} : SHADE_W'(sum);
		return r;
	endfunction

	// apply one accepted word to the shadow state
	task automatic absorb_word(input shader_word_t w);
		if (w.op == OP_TABLE_WRITE) begin
			gradient_mirror[int'(w.tidx) & (SLOTS - 1)] = w.tval;
		end else if (int'(w.px) < SCREEN_WIDTH_DEF && int'(w.py) < SCREEN_HEIGHT_DEF) begin
			pending_shades.push_back(shade_pixel(w));
		end
	endtask

	function automatic logic [TVAL_W-1:0] random_level();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return {TVAL_W{1'b1}};
			end
			2: begin
				return TVAL_W'($urandom_range(0, 511));
			end
			default: begin
				return TVAL_W'($urandom);
			end
		endcase
	endfunction

	task automatic queue_table_write(input int slot, input logic [TVAL_W-1:0] value);
		shader_word_t w;
		// coordinates are don't-care on a write, so let them toggle
		w.op = OP_TABLE_WRITE;
		w.px = COORD_W'($urandom);
		w.py = COORD_W'($urandom);
		w.tidx = TIDX_W'(slot);
		w.tval = value;
		queued_words.push_back(w);
		slot_written[slot & (SLOTS - 1)] = 1'b1;
	endtask

	task automatic queue_pixel(input int px, input int py);
		shader_word_t w;
		int           slot;
		slot = gradient_slot(COORD_W'(px), COORD_W'(py));
		// fill the entry first if nothing has been written there yet
		if (!slot_written[slot]) begin
			queue_table_write(slot, random_level());
		end
		w.op = OP_SHADE;
		w.px = COORD_W'(px);
		w.py = COORD_W'(py);
		w.tidx = TIDX_W'($urandom);
		w.tval = TVAL_W'($urandom);
		queued_words.push_back(w);
	endtask

	// wait until every word has gone in and every shade has come out, then let
	// the pipeline empty of writes that produce nothing
	task automatic settle();
		do begin
			@(negedge clk);
		end while (queued_words.size() != 0 || s_tvalid || pending_shades.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endtask

	// sender: bursts of random length with random gaps, fed from queued_words
	shader_word_t cur_word;
	int           gap_left   = 0;
	int           burst_left = 1;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			// the word on the bus, if any, has just been taken
			if (s_tvalid) begin
				absorb_word(cur_word);
			end
			if (gap_left > 0 || queued_words.size() == 0) begin
				s_tvalid <= 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end
			end else begin
				cur_word = queued_words.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= S_TDATA_W'({cur_word.tval, cur_word.tidx, cur_word.py, cur_word.px});
				s_tuser <= cur_word.op;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					case ($urandom_range(0, 19))
						0, 1, 2, 3, 4: begin
							gap_left = 0;
						end
						5, 6, 7: begin
							gap_left = $urandom_range(10, 40);
						end
						default: begin
							gap_left = $urandom_range(1, 6);
						end
					endcase
				end
			end
		end
	end

	// receiver: checks each shaded word and stalls on a changing pattern
	ready_mode_e   ready_mode = READY_ALWAYS;
	int            mode_left  = 0;
	int            beat       = 0;
	shaded_pixel_t want_pixel;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_shades.size() == 0) begin
					$error("result word with none outstanding: %h", m_tdata);
					failures++;
				end else begin
					want_pixel = pending_shades.pop_front();
					check_field("result_x", int'(want_pixel.x), int'(m_tdata[COORD_W-1:0]));
					check_field("result_y", int'(want_pixel.y),
						int'(m_tdata[2*COORD_W-1:COORD_W]));
					check_field("shade", int'(want_pixel.level),
						int'(m_tdata[2*COORD_W+SHADE_W-1:2*COORD_W]));
				end
			end
			if (mode_left == 0) begin
				ready_mode = ready_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 400);
			end
			mode_left--;
			beat++;
			case (ready_mode)
				READY_ALWAYS: begin
					m_tready <= 1'b1;
				end
				READY_COIN: begin
					m_tready <= 1'($urandom_range(0, 1));
				end
				READY_SPARSE: begin
					m_tready <= ($urandom_range(0, 7) == 0);
				end
				default: begin
					// ready on a repeating pattern set by the beat counter
					m_tready <= ((beat % 11) < 4);
				end
			endcase
		end
	end

	// watchdog on cycles in which no word moves either way
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("radial_gradient_dither_shader_core regression: fail");
				$finish;
			end
		end
	end

	logic signed [CTR_W-1:0] next_cx;
	logic signed [CTR_W-1:0] next_cy;
	logic [IRS_W-1:0]        next_irs;
	logic [3:0]              next_ib;
	logic [3:0]              next_os;
	logic [CFG_IDX_W-1:0]    reg_sel [5];
	logic [CFG_DATA_W-1:0]   reg_val [5];
	int                      radius;
	int                      near_x;
	int                      near_y;

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words under the reset settings: every pixel lands on entry 0
		queue_table_write(0, '0);
		queue_table_write(SLOTS - 1, {TVAL_W{1'b1}});
		// all sixteen dither positions against an empty entry, so negative offsets clamp
		for (int y = 0; y < 4; y++) begin
			for (int x = 0; x < 4; x++) begin
				queue_pixel(x, y);
			end
		end
		// full-scale entry: positive offsets push past 255 and saturate
		queue_table_write(0, {TVAL_W{1'b1}});
		queue_pixel(1023, 1023);
		queue_pixel(0, 1023);
		queue_pixel(1023, 0);
		queue_table_write(0, 16'h7f80);
		queue_pixel(513, 2);
		settle();

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			// the first four settings are fixed, three of them extremes, the rest random
			case (phase)
				0: begin
					next_cx = 16'sd512;
					next_cy = 16'sd384;
					next_irs = 32'hffff_ffff / (300 * 300);
					next_ib = 4'd8;
					next_os = 4'd8;
				end
				1: begin
					next_cx = -16'sd32768;
					next_cy = 16'sd32767;
					next_irs = 32'hffff_ffff;
					next_ib = 4'd1;
					next_os = 4'd12;
				end
				2: begin
					// index bits above the table depth and shift below range
					next_cx = 16'sd32767;
					next_cy = -16'sd32768;
					next_irs = 32'd1;
					next_ib = 4'd15;
					next_os = 4'd0;
				end
				3: begin
					// zero index bits and shift above range
					next_cx = '0;
					next_cy = '0;
					next_irs = '0;
					next_ib = 4'd0;
					next_os = 4'd15;
				end
				default: begin
					case ($urandom_range(0, 3))
						0: begin
							next_cx = CTR_W'($urandom);
							next_cy = CTR_W'($urandom);
						end
						1: begin
							next_cx = CTR_W'(int'($urandom_range(0, 1423)) - 200);
							next_cy = CTR_W'(int'($urandom_range(0, 1423)) - 200);
						end
						default: begin
							next_cx = CTR_W'($urandom_range(0, 1023));
							next_cy = CTR_W'($urandom_range(0, 1023));
						end
					endcase
					if ($urandom_range(0, 2) == 0) begin
						next_irs = $urandom;
					end else begin
						radius = $urandom_range(1, 1500);
						next_irs = 32'hffff_ffff / (radius * radius);
					end
					next_ib = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(1, 8));
					next_os = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(8, 12));
				end
			endcase

			// register writes while the core is idle, enable held high across them
			reg_sel[0] = REG_CENTER_X;
			reg_val[0] = CFG_DATA_W'($unsigned(next_cx));
			reg_sel[1] = REG_CENTER_Y;
			reg_val[1] = CFG_DATA_W'($unsigned(next_cy));
			reg_sel[2] = REG_INV_RADIUS2;
			reg_val[2] = CFG_DATA_W'(next_irs);
			reg_sel[3] = REG_INDEX_BITS;
			reg_val[3] = CFG_DATA_W'(next_ib);
			reg_sel[4] = REG_OUTPUT_SHIFT;
			reg_val[4] = CFG_DATA_W'(next_os);
			for (int i = 0; i < 5; i++) begin
				@(posedge clk);
				cfg_wr_en <= 1'b1;
				cfg_index <= reg_sel[i];
				cfg_wdata <= reg_val[i];
			end
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			centre_x_q = next_cx;
			centre_y_q = next_cy;
			inv_r2_q = next_irs;
			index_bits_q = next_ib;
			out_shift_q = next_os;

			// random mix of table writes and pixels, mostly pixels
			repeat (PHASE_CHOICES) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						queue_table_write($urandom_range(0, SLOTS - 1), random_level());
					end
					2, 3, 4: begin
						// close to the centre, clipped onto the screen
						near_x = int'(centre_x_q) + int'($urandom_range(0, 80)) - 40;
						near_y = int'(centre_y_q) + int'($urandom_range(0, 80)) - 40;
						near_x = (near_x < 0) ? 0 : (near_x > 1023) ? 1023 : near_x;
						near_y = (near_y < 0) ? 0 : (near_y > 1023) ? 1023 : near_y;
						queue_pixel(near_x, near_y);
					end
					default: begin
						queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
					end
				endcase
			end
			settle();
		end

		if (failures == 0) begin
			$display("radial_gradient_dither_shader_core regression: pass");
		end else begin
			$display("radial_gradient_dither_shader_core regression: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rgds_pkg.sv
hw/rtl/rgds_ram.sv
hw/rtl/rgds_dist.sv
hw/rtl/rgds_shade.sv
hw/rtl/radial_gradient_dither_shader_core.sv
bench/radial_gradient_dither_shader_core_test.sv
